// ----- src/assert_macros.svh -----
// ------------------------------------------------------------------------
// Assertion macros
// Shared helpers for clocked concurrent assertions with an active-low reset.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error(msg);

// When the trigger holds, the consequence must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) \
		(trig) |=> (cons)) else $error(msg);

`endif

// ----- src/slist_pkg.sv -----
// ------------------------------------------------------------------------
// Sequential list engine package
// Request kinds, result codes, sequencer states and shared structs.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slist_pkg;

	// Request kind carried on the input tuser field.
	typedef enum logic [1:0] {
		KIND_APPEND    = 2'd0,
		KIND_DELETE    = 2'd1,
		KIND_OVERWRITE = 2'd2,
		KIND_FIND      = 2'd3
	} kind_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_DONE    = 3'd0,
		ST_FULL    = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_RANGE   = 3'd3,
		ST_MISSING = 3'd4
	} status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SHIFT,
		S_DRAIN,
		S_SCAN,
		S_SCAN_LAST,
		S_RESP
	} state_t;

	// Memory port enables from the sequencer.
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

	// One result item.
	typedef struct packed {
		status_t    status;
		logic [7:0] found_position;
		logic [7:0] length_now;
	} result_t;

endpackage

`default_nettype wire

// ----- src/slist_mem.sv -----
// ------------------------------------------------------------------------
// List entry memory
// One write port and one read port with registered read data.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slist_mem #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  wire                    clk,
	input  slist_pkg::mem_ctl_t    ctl,
	input  wire [AW-1:0]           waddr,
	input  wire signed [31:0]      wdata,
	input  wire [AW-1:0]           raddr,
	output logic signed [31:0]     rdata
);

	logic signed [31:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port with registered read data.
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- src/slist_ctrl.sv -----
// ------------------------------------------------------------------------
// List sequencer
// Decodes a request, holds the entry count and walks the memory for the
// delete shift and the find scan.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slist_ctrl #(
	parameter int CAPACITY = 128,
	parameter int AW       = 7,
	parameter int CW       = 8
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     req_valid,
	output logic                    req_ready,
	input  slist_pkg::kind_t        req_kind,
	input  wire [7:0]               req_pos,
	input  wire signed [31:0]       req_value,
	output logic                    res_valid,
	input  wire                     res_ready,
	output slist_pkg::result_t      res,
	output slist_pkg::mem_ctl_t     mem_ctl,
	output logic [AW-1:0]           mem_waddr,
	output logic signed [31:0]      mem_wdata,
	output logic [AW-1:0]           mem_raddr,
	input  wire signed [31:0]       mem_rdata
);

	localparam int CMPW = (CW > 8) ? CW : 8;

	slist_pkg::state_t    state_q, state_d;
	slist_pkg::kind_t     kind_q;
	slist_pkg::status_t   status_q;
	logic [7:0]           pos_q;
	logic signed [31:0]   val_q;
	logic [CW-1:0]        count_q;
	logic [AW-1:0]        idx_q;
	logic [7:0]           found_q;
	logic                 cmp_s1;
	logic [AW-1:0]        idx_s1;
	logic                 shift_s1;
	logic [AW-1:0]        waddr_s1;

	logic [CMPW-1:0]      pos_ext, count_ext, found_full;
	logic                 pos_ok, is_full, is_empty, pos_is_last, idx_last, match;
	logic                 exec_wr;
	logic [AW-1:0]        exec_addr;

	// Request checks against the current count.
	always_comb begin
		pos_ext     = CMPW'(pos_q);
		count_ext   = CMPW'(count_q);
		pos_ok      = (pos_ext != '0) && (pos_ext <= count_ext);
		is_full     = (count_q == CW'(CAPACITY));
		is_empty    = (count_q == '0);
		pos_is_last = (pos_ext == count_ext);
		idx_last    = (CW'(idx_q) == (count_q - CW'(1)));
		match       = cmp_s1 && (mem_rdata == val_q);
		found_full  = CMPW'(idx_s1) + CMPW'(1);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			slist_pkg::S_IDLE: begin
				if (req_valid) state_d = slist_pkg::S_EXEC;
			end
			slist_pkg::S_EXEC: begin
				case (kind_q)
					slist_pkg::KIND_DELETE: begin
						if (is_empty || !pos_ok || pos_is_last) state_d = slist_pkg::S_RESP;
						else state_d = slist_pkg::S_SHIFT;
					end
					slist_pkg::KIND_FIND: begin
						if (is_empty) state_d = slist_pkg::S_RESP;
						else state_d = slist_pkg::S_SCAN;
					end
					default: state_d = slist_pkg::S_RESP;
				endcase
			end
			slist_pkg::S_SHIFT: begin
				if (idx_last) state_d = slist_pkg::S_DRAIN;
			end
			slist_pkg::S_DRAIN: state_d = slist_pkg::S_RESP;
			slist_pkg::S_SCAN: begin
				if (match) state_d = slist_pkg::S_RESP;
				else if (idx_last) state_d = slist_pkg::S_SCAN_LAST;
			end
			slist_pkg::S_SCAN_LAST: state_d = slist_pkg::S_RESP;
			slist_pkg::S_RESP: begin
				if (res_ready) state_d = slist_pkg::S_IDLE;
			end
			default: state_d = slist_pkg::S_IDLE;
		endcase
	end

	// Handshake and memory port outputs.
	always_comb begin
		req_ready = (state_q == slist_pkg::S_IDLE);
		res_valid = (state_q == slist_pkg::S_RESP);

		exec_wr   = 1'b0;
		exec_addr = count_q[AW-1:0];
		if (state_q == slist_pkg::S_EXEC) begin
			case (kind_q)
				slist_pkg::KIND_APPEND: begin
					exec_wr   = !is_full;
					exec_addr = count_q[AW-1:0];
				end
				slist_pkg::KIND_OVERWRITE: begin
					exec_wr   = pos_ok;
					exec_addr = AW'(pos_ext - CMPW'(1));
				end
				default: exec_wr = 1'b0;
			endcase
		end

		mem_ctl.wr_en = exec_wr || shift_s1;
		mem_ctl.rd_en = (state_q == slist_pkg::S_SHIFT) || (state_q == slist_pkg::S_SCAN);
		mem_waddr     = shift_s1 ? waddr_s1 : exec_addr;
		mem_wdata     = shift_s1 ? mem_rdata : val_q;
		mem_raddr     = idx_q;

		res.status         = status_q;
		res.found_position = found_q;
		res.length_now     = count_ext[7:0];
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= slist_pkg::S_IDLE;
			count_q  <= '0;
			cmp_s1   <= 1'b0;
			shift_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			cmp_s1   <= (state_q == slist_pkg::S_SCAN);
			shift_s1 <= (state_q == slist_pkg::S_SHIFT);
			if (state_q == slist_pkg::S_EXEC) begin
				case (kind_q)
					slist_pkg::KIND_APPEND: begin
						if (!is_full) count_q <= count_q + CW'(1);
					end
					slist_pkg::KIND_DELETE: begin
						if (!is_empty && pos_ok && pos_is_last) count_q <= count_q - CW'(1);
					end
					default: count_q <= count_q;
				endcase
			end else if (state_q == slist_pkg::S_DRAIN) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Request, index and result registers.
	always_ff @(posedge clk) begin
		idx_s1   <= idx_q;
		waddr_s1 <= idx_q - AW'(1);
		case (state_q)
			slist_pkg::S_IDLE: begin
				if (req_valid) begin
					kind_q   <= req_kind;
					pos_q    <= req_pos;
					val_q    <= req_value;
					status_q <= slist_pkg::ST_DONE;
					found_q  <= '0;
				end
			end
			slist_pkg::S_EXEC: begin
				case (kind_q)
					slist_pkg::KIND_APPEND: begin
						if (is_full) status_q <= slist_pkg::ST_FULL;
					end
					slist_pkg::KIND_DELETE: begin
						if (is_empty) status_q <= slist_pkg::ST_EMPTY;
						else if (!pos_ok) status_q <= slist_pkg::ST_RANGE;
						idx_q <= AW'(pos_ext);
					end
					slist_pkg::KIND_OVERWRITE: begin
						if (!pos_ok) status_q <= slist_pkg::ST_RANGE;
					end
					default: begin
						if (is_empty) status_q <= slist_pkg::ST_MISSING;
						idx_q <= '0;
					end
				endcase
			end
			slist_pkg::S_SHIFT: idx_q <= idx_q + AW'(1);
			slist_pkg::S_SCAN: begin
				if (match) found_q <= found_full[7:0];
				idx_q <= idx_q + AW'(1);
			end
			slist_pkg::S_SCAN_LAST: begin
				if (match) found_q <= found_full[7:0];
				else status_q <= slist_pkg::ST_MISSING;
			end
			default: idx_q <= idx_q;
		endcase
	end

endmodule

`default_nettype wire

// ----- src/sequential_list_engine_top.sv -----
// ------------------------------------------------------------------------
// Sequential list engine
// Ordered list of signed 32-bit words with append, delete, overwrite, find.
// ------------------------------------------------------------------------
// Usage:
// A request enters on the s_axis channel: tuser carries the kind, tdata the
// position and the value. Each request gives exactly one result transaction
// on the m_axis channel with the status, the found position and the length.
// Requests are worked one at a time. Append, overwrite, refused requests and
// a delete of the last entry pass from the execute state straight to the
// result state. A delete at position p moves count - p entries through the
// single memory port pair, one per cycle. A find reads one entry a cycle
// until it matches or reaches the last entry. A result waits in an output
// register, so the next request is accepted while the receiver stalls; its
// result is held back until the register is free. Reset empties the list at
// once; entries are not cleared.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sequential_list_engine_top #(
	parameter int CAPACITY = 128
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire [39:0]  s_axis_tdata,  // [7:0] position, [39:8] value
	input  wire [1:0]   s_axis_tuser,  // [1:0] kind
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [23:0] m_axis_tdata   // [2:0] status, [10:3] found_position,
	                                   // [18:11] length_now, [23:19] zero
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	slist_pkg::mem_ctl_t mem_ctl;
	slist_pkg::result_t  res;
	slist_pkg::result_t  res_q;
	logic [AW-1:0]       mem_waddr, mem_raddr;
	logic signed [31:0]  mem_wdata, mem_rdata;
	logic                res_valid, res_ready;
	logic                m_valid_q;

	// Sequencer with the count and the request decode.
	slist_ctrl #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CW       (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.req_kind  (slist_pkg::kind_t'(s_axis_tuser)),
		.req_pos   (s_axis_tdata[7:0]),
		.req_value (s_axis_tdata[39:8]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_ctl   (mem_ctl),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// Entry storage.
	slist_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.ctl   (mem_ctl),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Output register: loads when empty or when its transaction completes.
	assign res_ready = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {5'd0, res_q.length_now, res_q.found_position, res_q.status};

	// The engine is not ready for a request in the cycle after taking one.
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_axis_tvalid && s_axis_tready,
		!s_axis_tready, "request accepted while the engine was busy")

	// A result handed to the output register is shown in the next cycle.
	`ASSERT_NEXT(a_result_shown, clk, arst_n, res_valid && res_ready,
		m_axis_tvalid, "result lost on its way to the output register")

	// A missing value never reports a position.
	`ASSERT_CLK(a_missing_no_pos, clk, arst_n,
		!m_valid_q || (res_q.status != slist_pkg::ST_MISSING) ||
		(res_q.found_position == 8'd0), "not-found result carries a position")

endmodule

`default_nettype wire
